// ----- rtl/seu_pkg.sv -----
// Shared types, character codes and UTF-8 helper functions for the string unescaper.
`default_nettype none

package seu_pkg;

    // Parser modes while walking through an escaped string.
    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_UDIG   = 3'd2,
        M_HS_BS  = 3'd3,
        M_HS_U   = 3'd4,
        M_HS_DIG = 3'd5
    } t_mode;

    localparam int unsigned BURST_MAX = 8;

    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_U      = 8'h75;
    localparam logic [7:0] C_T      = 8'h74;
    localparam logic [7:0] C_N      = 8'h6E;
    localparam logic [7:0] C_R      = 8'h72;
    localparam logic [7:0] C_B      = 8'h62;
    localparam logic [7:0] C_F      = 8'h66;

    localparam logic [15:0] C_HIGH_MIN = 16'hD800;
    localparam logic [15:0] C_HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] C_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] C_LOW_MAX  = 16'hDFFF;
    localparam logic [20:0] C_SUPP_BASE = 21'h10000;
    localparam logic [20:0] C_MAX_1B   = 21'h7F;
    localparam logic [20:0] C_MAX_2B   = 21'h7FF;
    localparam logic [20:0] C_MAX_3B   = 21'hFFFF;
    localparam logic [4:0]  C_LEAD_2B  = 5'b11000;
    localparam logic [3:0]  C_LEAD_3B  = 4'b1110;
    localparam logic [4:0]  C_LEAD_4B  = 5'b11110;
    localparam logic [1:0]  C_CONT     = 2'b10;
    localparam logic [5:0]  C_HIGH_TOP = 6'b110110;

    // A short run of bytes, lowest byte first.
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } t_seg;

    // All bytes that one input word produces, first byte in the lowest bits.
    typedef struct packed {
        logic [8*BURST_MAX-1:0] data;
        logic [3:0]             cnt;
        logic                   str_end;
    } t_burst;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end
        hex_val = d[3:0];
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        case (c)
            C_T:     esc_map = 8'h09;
            C_N:     esc_map = 8'h0A;
            C_R:     esc_map = 8'h0D;
            C_B:     esc_map = 8'h08;
            C_F:     esc_map = 8'h0C;
            default: esc_map = c;
        endcase
    endfunction

    function automatic t_seg one_byte(input logic [7:0] c);
        t_seg s;
        s.bytes = {24'h0, c};
        s.len   = 3'd1;
        one_byte = s;
    endfunction

    function automatic t_seg utf8_enc(input logic [20:0] cp);
        t_seg s;
        if (cp <= C_MAX_1B) begin
            s.bytes = {24'h0, cp[7:0]};
            s.len   = 3'd1;
        end else if (cp <= C_MAX_2B) begin
            s.bytes = {16'h0, C_CONT, cp[5:0], C_LEAD_2B[4:2], cp[10:6]};
            s.len   = 3'd2;
        end else if (cp <= C_MAX_3B) begin
            s.bytes = {8'h0, C_CONT, cp[5:0], C_CONT, cp[11:6], C_LEAD_3B, cp[15:12]};
            s.len   = 3'd3;
        end else begin
            s.bytes = {C_CONT, cp[5:0], C_CONT, cp[11:6], C_CONT, cp[17:12],
                       C_LEAD_4B, cp[20:18]};
            s.len   = 3'd4;
        end
        utf8_enc = s;
    endfunction

    // Rebuilds a held high surrogate from its low ten bits and encodes it.
    function automatic t_seg high_enc(input logic [9:0] hu);
        high_enc = utf8_enc({5'h00, C_HIGH_TOP, hu});
    endfunction

    // A broken \u escape: the letter u followed by the digits seen so far.
    function automatic t_seg partial_seg(input logic [1:0] cnt,
                                         input logic [2:0][7:0] held);
        t_seg s;
        s.bytes = {held[2], held[1], held[0], C_U};
        s.len   = 3'({1'b0, cnt}) + 3'd1;
        partial_seg = s;
    endfunction

    function automatic t_burst push(input t_burst o, input t_seg s);
        t_burst r;
        logic [3:0] pos;
        logic [3:0] sum;
        r = o;
        for (int k = 0; k < 4; k++) begin
            pos = o.cnt + 4'(k);
            if ((3'(k) < s.len) && (pos < 4'(BURST_MAX))) begin
                r.data[pos[2:0]*8 +: 8] = s.bytes[k*8 +: 8];
            end
        end
        sum = o.cnt + {1'b0, s.len};
        r.cnt = (sum > 4'(BURST_MAX)) ? 4'(BURST_MAX) : sum;
        push = r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/seu_step.sv -----
// Parser state registers and the per-word unescape logic that builds one output burst.
`default_nettype none

module seu_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    output seu_pkg::t_burst      o_burst
);
    import seu_pkg::*;

    t_mode            r_mode, n_mode;
    logic [1:0]       r_cnt, n_cnt;
    logic [11:0]      r_acc, n_acc;
    logic [9:0]       r_hu, n_hu;
    logic [2:0][7:0]  r_held, n_held;

    logic             hex;
    logic [15:0]      full;
    logic             full_high;
    logic             full_low;

    assign hex       = is_hex(i_byte);
    assign full      = {r_acc, hex_val(i_byte)};
    assign full_high = (full >= C_HIGH_MIN) && (full <= C_HIGH_MAX);
    assign full_low  = (full >= C_LOW_MIN) && (full <= C_LOW_MAX);

    // Next state after the byte itself; the end-of-string flush is applied at the register.
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_hu   = r_hu;
        n_held = r_held;
        case (r_mode)
            M_ESC: begin
                if (i_byte == C_U) begin
                    n_mode = M_UDIG;
                    n_cnt  = 2'd0;
                    n_acc  = 12'h000;
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            M_UDIG, M_HS_DIG: begin
                if (hex) begin
                    if (r_cnt == 2'd3) begin
                        n_cnt = 2'd0;
                        n_acc = 12'h000;
                        if ((r_mode == M_HS_DIG) && full_low) begin
                            n_mode = M_NORMAL;
                        end else if (full_high) begin
                            n_hu   = full[9:0];
                            n_mode = M_HS_BS;
                        end else begin
                            n_mode = M_NORMAL;
                        end
                    end else begin
                        n_held[r_cnt] = i_byte;
                        n_acc         = full[11:0];
                        n_cnt         = r_cnt + 2'd1;
                    end
                end else begin
                    n_cnt  = 2'd0;
                    n_acc  = 12'h000;
                    n_mode = (i_byte == C_BSLASH) ? M_ESC : M_NORMAL;
                end
            end
            M_HS_BS: begin
                n_mode = (i_byte == C_BSLASH) ? M_HS_U : M_NORMAL;
            end
            M_HS_U: begin
                if (i_byte == C_U) begin
                    n_mode = M_HS_DIG;
                    n_cnt  = 2'd0;
                    n_acc  = 12'h000;
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            default: begin
                n_mode = (i_byte == C_BSLASH) ? M_ESC : M_NORMAL;
            end
        endcase
    end

    // Bytes emitted by the byte itself, then by the flush when it ends the string.
    always_comb begin
        t_burst o;
        o = '0;
        case (r_mode)
            M_ESC: begin
                if (i_byte != C_U) begin
                    o = push(o, one_byte(esc_map(i_byte)));
                end
            end
            M_UDIG: begin
                if (hex) begin
                    if ((r_cnt == 2'd3) && !full_high) begin
                        o = push(o, utf8_enc({5'h00, full}));
                    end
                end else begin
                    o = push(o, partial_seg(r_cnt, r_held));
                    if (i_byte != C_BSLASH) begin
                        o = push(o, one_byte(i_byte));
                    end
                end
            end
            M_HS_BS: begin
                if (i_byte != C_BSLASH) begin
                    o = push(o, high_enc(r_hu));
                    o = push(o, one_byte(i_byte));
                end
            end
            M_HS_U: begin
                if (i_byte != C_U) begin
                    o = push(o, high_enc(r_hu));
                    o = push(o, one_byte(esc_map(i_byte)));
                end
            end
            M_HS_DIG: begin
                if (hex) begin
                    if (r_cnt == 2'd3) begin
                        if (full_low) begin
                            o = push(o, utf8_enc(C_SUPP_BASE + {1'b0, r_hu, full[9:0]}));
                        end else begin
                            o = push(o, high_enc(r_hu));
                            if (!full_high) begin
                                o = push(o, utf8_enc({5'h00, full}));
                            end
                        end
                    end
                end else begin
                    o = push(o, high_enc(r_hu));
                    o = push(o, partial_seg(r_cnt, r_held));
                    if (i_byte != C_BSLASH) begin
                        o = push(o, one_byte(i_byte));
                    end
                end
            end
            default: begin
                if (i_byte != C_BSLASH) begin
                    o = push(o, one_byte(i_byte));
                end
            end
        endcase
        if (i_last) begin
            case (n_mode)
                M_ESC:   o = push(o, one_byte(C_BSLASH));
                M_UDIG:  o = push(o, partial_seg(n_cnt, n_held));
                M_HS_BS: o = push(o, high_enc(n_hu));
                M_HS_U: begin
                    o = push(o, high_enc(n_hu));
                    o = push(o, one_byte(C_BSLASH));
                end
                M_HS_DIG: begin
                    o = push(o, high_enc(n_hu));
                    o = push(o, partial_seg(n_cnt, n_held));
                end
                default: o = o;
            endcase
        end
        o.str_end = i_last;
        o_burst   = o;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_cnt  <= 2'd0;
            r_acc  <= 12'h000;
            r_hu   <= 10'h000;
        end else if (i_adv) begin
            if (i_last) begin
                r_mode <= M_NORMAL;
                r_cnt  <= 2'd0;
                r_acc  <= 12'h000;
                r_hu   <= 10'h000;
            end else begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_acc  <= n_acc;
                r_hu   <= n_hu;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/seu_burst.sv -----
// Output burst register that hands the bytes of one input word out one at a time, as the downstream side takes them.
`default_nettype none

module seu_burst (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  seu_pkg::t_burst      i_burst,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_byte,
    output logic                 o_run_last,
    output logic                 o_str_end
);
    import seu_pkg::*;

    logic [8*BURST_MAX-1:0] r_data;
    logic [3:0]             r_cnt;
    logic                   r_end;
    logic                   pop;

    assign pop        = o_valid && i_ready;
    assign o_valid    = (r_cnt != 4'd0);
    // A new burst may load while the final byte of the current one leaves.
    assign o_free     = (r_cnt == 4'd0) || ((r_cnt == 4'd1) && i_ready);
    assign o_byte     = r_data[7:0];
    assign o_run_last = (r_cnt == 4'd1);
    assign o_str_end  = (r_cnt == 4'd1) && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_burst.data;
            r_end  <= i_burst.str_end;
        end else if (pop) begin
            r_data <= {8'h00, r_data[8*BURST_MAX-1:8]};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/string_escape_unescaper_utf8_core.sv -----
// Top level of the streaming string unescaper with UTF-8 output.
// The first output byte of a word is offered once the word has moved from the input
// register into the output burst register; a busy burst register holds it back.
// Input words are taken one per cycle while each word yields at most one byte and the
// output side is ready; a word that yields more bytes (up to 8) holds the burst register
// until all are taken. A word that yields no bytes only updates the parser state.
// Reset (synchronous, active low) empties the input and burst registers and returns
// the parser to plain text mode.
`default_nettype none

module string_escape_unescaper_utf8_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // string_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // [0] string_end
);
    import seu_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        adv;
    logic        burst_free;
    t_burst      burst;

    assign adv           = r_in_valid && burst_free;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    seu_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_burst (burst)
    );

    seu_burst u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_burst    (burst),
        .o_free     (burst_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_run_last (m_axis_tlast),
        .o_str_end  (m_axis_tuser)
    );

endmodule

`default_nettype wire
